@@ hw/rtl/ocpf_pkg.sv @@
package ocpf_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int MAX_RADIUS = 4;

    localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int COORD_W  = 32;
    localparam int SUM_W    = 40;
    localparam int CNT_W    = 7;
    localparam int DIM_W    = 9;
    localparam int RAD_W    = 3;
    localparam int POS_W    = 10;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_RADIUS = 2'd2;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [1:0] ST_HIT   = 2'd0;
    localparam logic [1:0] ST_AVG   = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic clear_wr;
        logic pt_wr;
        logic load_query;
        logic rd_center;
        logic acc_clear;
        logic acc_add;
        logic div_start;
        logic set_hit;
        logic set_zero;
        logic out_load;
        logic win_init;
        logic win_step;
    } ctrl_t;

    typedef struct packed {
        logic out_range;
        logic cell_in;
        logic win_last;
        logic rd_valid;
        logic cnt_zero;
        logic div_done;
        logic clear_last;
    } stat_t;

endpackage

@@ hw/rtl/ocpf_ram.sv @@
module ocpf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/ocpf_div.sv @@
module ocpf_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [ocpf_pkg::SUM_W-1:0]   num_x,
    input  logic signed [ocpf_pkg::SUM_W-1:0]   num_y,
    input  logic signed [ocpf_pkg::SUM_W-1:0]   num_z,
    input  logic [ocpf_pkg::CNT_W-1:0]          den,
    output logic                                done,
    output logic [ocpf_pkg::COORD_W-1:0]        q_x,
    output logic [ocpf_pkg::COORD_W-1:0]        q_y,
    output logic [ocpf_pkg::COORD_W-1:0]        q_z
);

    localparam int SW = ocpf_pkg::SUM_W;
    localparam int CW = ocpf_pkg::CNT_W;
    localparam int BW = $clog2(SW + 1);

    logic [SW-1:0] qx_reg, qy_reg, qz_reg;
    logic [SW-1:0] qx_next, qy_next, qz_next;
    logic [CW:0]   rx_reg, ry_reg, rz_reg;
    logic [CW:0]   rx_next, ry_next, rz_next;
    logic [2:0]    neg_reg;
    logic [CW-1:0] den_reg;
    logic [BW-1:0] bit_reg;
    logic          busy_reg;

    function automatic logic [SW-1:0] mag(input logic signed [SW-1:0] a);
        mag = a[SW-1] ? SW'(-a) : SW'(a);
    endfunction

    function automatic logic [CW:0] rstep(input logic [CW:0] r, input logic b,
                                          input logic [CW-1:0] d, output logic qb);
        logic [CW+1:0] t;
        t = {r, b};
        if (t >= {2'b00, d})
        begin
            qb = 1'b1;
            t  = t - {2'b00, d};
        end
        else
        begin
            qb = 1'b0;
        end
        rstep = t[CW:0];
    endfunction

    always_comb
    begin
        logic bx, by, bz;
        rx_next = rstep(rx_reg, qx_reg[SW-1], den_reg, bx);
        ry_next = rstep(ry_reg, qy_reg[SW-1], den_reg, by);
        rz_next = rstep(rz_reg, qz_reg[SW-1], den_reg, bz);
        qx_next = {qx_reg[SW-2:0], bx};
        qy_next = {qy_reg[SW-2:0], by};
        qz_next = {qz_reg[SW-2:0], bz};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            bit_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                bit_reg  <= BW'(SW);
            end
            else if (busy_reg)
            begin
                bit_reg <= bit_reg - 1'b1;
                if (bit_reg == BW'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            qx_reg  <= mag(num_x);
            qy_reg  <= mag(num_y);
            qz_reg  <= mag(num_z);
            rx_reg  <= '0;
            ry_reg  <= '0;
            rz_reg  <= '0;
            den_reg <= den;
            neg_reg <= {num_x[SW-1], num_y[SW-1], num_z[SW-1]};
        end
        else if (busy_reg)
        begin
            qx_reg <= qx_next;
            qy_reg <= qy_next;
            qz_reg <= qz_next;
            rx_reg <= rx_next;
            ry_reg <= ry_next;
            rz_reg <= rz_next;
        end
    end

    assign q_x = neg_reg[2] ? ocpf_pkg::COORD_W'(-qx_reg) : qx_reg[ocpf_pkg::COORD_W-1:0];
    assign q_y = neg_reg[1] ? ocpf_pkg::COORD_W'(-qy_reg) : qy_reg[ocpf_pkg::COORD_W-1:0];
    assign q_z = neg_reg[0] ? ocpf_pkg::COORD_W'(-qz_reg) : qz_reg[ocpf_pkg::COORD_W-1:0];

endmodule

@@ hw/rtl/ocpf_datapath.sv @@
module ocpf_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ocpf_pkg::ctrl_t                      ctrl,
    output ocpf_pkg::stat_t                      stat,
    input  logic                                 cfg_we,
    input  logic [1:0]                           cfg_index,
    input  logic [ocpf_pkg::DIM_W-1:0]           cfg_data,
    input  logic [15:0]                          point_index,
    input  logic signed [ocpf_pkg::COORD_W-1:0]  point_x,
    input  logic signed [ocpf_pkg::COORD_W-1:0]  point_y,
    input  logic signed [ocpf_pkg::COORD_W-1:0]  point_z,
    input  logic                                 point_ok,
    input  logic [7:0]                           query_u,
    input  logic [7:0]                           query_v,
    output logic signed [ocpf_pkg::COORD_W-1:0]  out_x,
    output logic signed [ocpf_pkg::COORD_W-1:0]  out_y,
    output logic signed [ocpf_pkg::COORD_W-1:0]  out_z,
    output logic [1:0]                           fill_status,
    output logic [ocpf_pkg::CNT_W-1:0]           used_count
);

    localparam int AW = ocpf_pkg::ADDR_W;
    localparam int CW = ocpf_pkg::COORD_W;
    localparam int SW = ocpf_pkg::SUM_W;
    localparam int PW = ocpf_pkg::POS_W;
    localparam int DW = ocpf_pkg::DIM_W;

    logic [DW-1:0]  width_reg, height_reg;
    logic [2:0]     radius_reg;
    logic [DW-1:0]  w_eff, h_eff;
    logic [2:0]     r_eff;
    logic [7:0]     u_reg, v_reg;
    logic signed [PW-1:0] i_reg, j_reg;
    logic [AW-1:0]  clr_reg;
    logic [AW-1:0]  raddr;
    logic [AW-1:0]  center_addr, cell_addr;
    logic [CW-1:0]  rx, ry, rz;
    logic           rv;
    logic signed [SW-1:0] sx_reg, sy_reg, sz_reg;
    logic [ocpf_pkg::CNT_W-1:0] cnt_reg;
    logic           div_done;
    logic [CW-1:0]  qx, qy, qz;
    logic [AW-1:0]  v_waddr;
    logic           v_wdata;
    logic           v_we;

    assign w_eff = (width_reg > DW'(ocpf_pkg::MAX_WIDTH)) ? DW'(ocpf_pkg::MAX_WIDTH) : width_reg;
    assign h_eff = (height_reg > DW'(ocpf_pkg::MAX_HEIGHT)) ? DW'(ocpf_pkg::MAX_HEIGHT) : height_reg;
    assign r_eff = (radius_reg > 3'(ocpf_pkg::MAX_RADIUS)) ? 3'(ocpf_pkg::MAX_RADIUS) : radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DW'(256);
            height_reg <= DW'(256);
            radius_reg <= 3'd1;
            clr_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ocpf_pkg::CFG_WIDTH:  width_reg  <= cfg_data;
                    ocpf_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                    ocpf_pkg::CFG_RADIUS: radius_reg <= cfg_data[2:0];
                    default: ;
                endcase
            end
            if (ctrl.clear_wr)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
        end
    end

    assign center_addr = AW'(u_reg) + AW'(AW'(v_reg) * AW'(w_eff));
    assign cell_addr   = AW'(i_reg) + AW'(AW'(j_reg) * AW'(w_eff));

    assign raddr = ctrl.rd_center ? center_addr : cell_addr;

    assign stat.out_range  = ({1'b0, u_reg} >= w_eff) || ({1'b0, v_reg} >= h_eff);
    assign stat.cell_in    = (i_reg >= 0) && (i_reg < PW'(signed'({1'b0, w_eff})))
                          && (j_reg >= 0) && (j_reg < PW'(signed'({1'b0, h_eff})));
    assign stat.win_last   = (i_reg == PW'(signed'({2'b0, u_reg})) + PW'(signed'({1'b0, r_eff})))
                          && (j_reg == PW'(signed'({2'b0, v_reg})) + PW'(signed'({1'b0, r_eff})));
    assign stat.rd_valid   = rv;
    assign stat.cnt_zero   = (cnt_reg == '0);
    assign stat.div_done   = div_done;
    assign stat.clear_last = (clr_reg == {AW{1'b1}});

    always_ff @(posedge clk)
    begin
        if (ctrl.load_query)
        begin
            u_reg <= query_u;
            v_reg <= query_v;
        end
        if (ctrl.win_init)
        begin
            i_reg <= PW'(signed'({2'b0, u_reg})) - PW'(signed'({1'b0, r_eff}));
            j_reg <= PW'(signed'({2'b0, v_reg})) - PW'(signed'({1'b0, r_eff}));
        end
        else if (ctrl.win_step)
        begin
            if (j_reg == PW'(signed'({2'b0, v_reg})) + PW'(signed'({1'b0, r_eff})))
            begin
                j_reg <= PW'(signed'({2'b0, v_reg})) - PW'(signed'({1'b0, r_eff}));
                i_reg <= i_reg + 1'b1;
            end
            else
            begin
                j_reg <= j_reg + 1'b1;
            end
        end
        if (ctrl.acc_clear)
        begin
            sx_reg  <= '0;
            sy_reg  <= '0;
            sz_reg  <= '0;
            cnt_reg <= '0;
        end
        else if (ctrl.acc_add)
        begin
            sx_reg  <= sx_reg + SW'(signed'(rx));
            sy_reg  <= sy_reg + SW'(signed'(ry));
            sz_reg  <= sz_reg + SW'(signed'(rz));
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (ctrl.out_load)
        begin
            if (ctrl.set_hit)
            begin
                out_x       <= rx;
                out_y       <= ry;
                out_z       <= rz;
                fill_status <= ocpf_pkg::ST_HIT;
                used_count  <= 7'd1;
            end
            else if (ctrl.set_zero)
            begin
                out_x       <= '0;
                out_y       <= '0;
                out_z       <= '0;
                fill_status <= stat.out_range ? ocpf_pkg::ST_RANGE : ocpf_pkg::ST_EMPTY;
                used_count  <= '0;
            end
            else
            begin
                out_x       <= qx;
                out_y       <= qy;
                out_z       <= qz;
                fill_status <= ocpf_pkg::ST_AVG;
                used_count  <= cnt_reg;
            end
        end
    end

    assign v_we    = ctrl.clear_wr || ctrl.pt_wr;
    assign v_waddr = ctrl.clear_wr ? clr_reg : point_index[AW-1:0];
    assign v_wdata = ctrl.clear_wr ? 1'b0 : point_ok;

    ocpf_ram #(.WIDTH(CW), .DEPTH(ocpf_pkg::DEPTH)) u_xram (
        .clk(clk), .we(ctrl.pt_wr), .waddr(point_index[AW-1:0]), .wdata(point_x),
        .raddr(raddr), .rdata(rx));
    ocpf_ram #(.WIDTH(CW), .DEPTH(ocpf_pkg::DEPTH)) u_yram (
        .clk(clk), .we(ctrl.pt_wr), .waddr(point_index[AW-1:0]), .wdata(point_y),
        .raddr(raddr), .rdata(ry));
    ocpf_ram #(.WIDTH(CW), .DEPTH(ocpf_pkg::DEPTH)) u_zram (
        .clk(clk), .we(ctrl.pt_wr), .waddr(point_index[AW-1:0]), .wdata(point_z),
        .raddr(raddr), .rdata(rz));
    ocpf_ram #(.WIDTH(1), .DEPTH(ocpf_pkg::DEPTH)) u_vram (
        .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
        .raddr(raddr), .rdata(rv));

    ocpf_div u_div (
        .clk(clk), .rst_n(rst_n), .start(ctrl.div_start),
        .num_x(sx_reg), .num_y(sy_reg), .num_z(sz_reg), .den(cnt_reg),
        .done(div_done), .q_x(qx), .q_y(qy), .q_z(qz));

endmodule

@@ hw/rtl/ocpf_ctrl.sv @@
module ocpf_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic            action,
    input  logic            out_stall,
    output logic            out_valid,
    output ocpf_pkg::ctrl_t ctrl,
    input  ocpf_pkg::stat_t stat
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_CENTER = 3'd3;
    localparam logic [2:0] S_WALK   = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       acc_pend_reg, acc_pend_next;
    logic       last_pend_reg, last_pend_next;
    logic       out_valid_next;
    logic       in_acc;

    assign in_stall = (state_reg != S_IDLE) || out_valid;
    assign in_acc   = in_valid && !in_stall;

    always_comb
    begin
        ctrl           = '0;
        state_next     = state_reg;
        acc_pend_next  = 1'b0;
        last_pend_next = 1'b0;
        out_valid_next = out_valid && out_stall;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctrl.clear_wr = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (action == ocpf_pkg::ACT_WRITE)
                    begin
                        ctrl.pt_wr = 1'b1;
                    end
                    else
                    begin
                        ctrl.load_query = 1'b1;
                        state_next      = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                ctrl.acc_clear = 1'b1;
                ctrl.win_init  = 1'b1;
                ctrl.rd_center = 1'b1;
                if (stat.out_range)
                begin
                    ctrl.set_zero  = 1'b1;
                    ctrl.out_load  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_CENTER;
                end
            end
            S_CENTER:
            begin
                if (stat.rd_valid)
                begin
                    ctrl.set_hit   = 1'b1;
                    ctrl.out_load  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    acc_pend_next  = stat.cell_in;
                    last_pend_next = stat.win_last;
                    ctrl.win_step  = 1'b1;
                    state_next     = S_WALK;
                end
            end
            S_WALK:
            begin
                ctrl.acc_add = acc_pend_reg && stat.rd_valid;
                if (last_pend_reg)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    acc_pend_next  = stat.cell_in;
                    last_pend_next = stat.win_last;
                    ctrl.win_step  = 1'b1;
                end
            end
            S_DIV:
            begin
                if (stat.cnt_zero)
                begin
                    ctrl.set_zero  = 1'b1;
                    ctrl.out_load  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    ctrl.div_start = 1'b1;
                    state_next     = S_OUT;
                end
            end
            S_OUT:
            begin
                if (stat.div_done)
                begin
                    ctrl.out_load  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            acc_pend_reg  <= 1'b0;
            last_pend_reg <= 1'b0;
            out_valid     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_pend_reg  <= acc_pend_next;
            last_pend_reg <= last_pend_next;
            out_valid     <= out_valid_next;
        end
    end

endmodule

@@ hw/rtl/organized_cloud_point_fill_top.sv @@
// Organized point cloud store with hole filling.
// Input channel (in_valid/in_stall): action 0 writes point_x/y/z and point_ok
// at point_index, action 1 queries pixel (query_u, query_v).
// Output channel (out_valid/out_stall): one item per query with out_x/y/z,
// fill_status and used_count; writes give no item.
// Writes stream at one per cycle while no query is in flight or held for output.
// A query checks the pixel range and reads the center cell; a hit or an
// out-of-range pixel ends there. For a hole it walks the (2r+1)^2 window
// and runs the serial divider when any neighbor is valid. The window walk
// reads one cell per cycle from the coordinate and valid memories; the
// divider retires one quotient bit per cycle.
// After reset the valid memory is cleared one entry per cycle, all 65536
// entries, while no item is taken; configuration writes are taken at any time.
// A result waits in the output register while out_stall is high; no new item
// is taken until it leaves.
module organized_cloud_point_fill_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [8:0]          cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                action,
    input  logic [15:0]         point_index,
    input  logic signed [31:0]  point_x,
    input  logic signed [31:0]  point_y,
    input  logic signed [31:0]  point_z,
    input  logic                point_ok,
    input  logic [7:0]          query_u,
    input  logic [7:0]          query_v,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  out_x,
    output logic signed [31:0]  out_y,
    output logic signed [31:0]  out_z,
    output logic [1:0]          fill_status,
    output logic [6:0]          used_count
);

    ocpf_pkg::ctrl_t ctrl;
    ocpf_pkg::stat_t stat;

    ocpf_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .out_stall(out_stall), .out_valid(out_valid),
        .ctrl(ctrl), .stat(stat));

    ocpf_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .stat(stat),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .point_index(point_index), .point_x(point_x), .point_y(point_y),
        .point_z(point_z), .point_ok(point_ok), .query_u(query_u), .query_v(query_v),
        .out_x(out_x), .out_y(out_y), .out_z(out_z),
        .fill_status(fill_status), .used_count(used_count));

endmodule

@@ sim/tb_organized_cloud_point_fill_top.sv @@
module tb_organized_cloud_point_fill_top;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int DRAIN_CYCLES = 150;

    typedef struct {
        logic              act;
        logic [15:0]       idx;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic              ok;
        logic [7:0]        u;
        logic [7:0]        v;
    } cloud_item_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [1:0]         status;
        logic [6:0]         count;
    } fill_result_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [8:0]         cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic               action;
    logic [15:0]        point_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               point_ok;
    logic [7:0]         query_u;
    logic [7:0]         query_v;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [1:0]         fill_status;
    logic [6:0]         used_count;

    organized_cloud_point_fill_top dut (.*);

    logic signed [31:0] cloud_x [ocpf_pkg::DEPTH];
    logic signed [31:0] cloud_y [ocpf_pkg::DEPTH];
    logic signed [31:0] cloud_z [ocpf_pkg::DEPTH];
    bit                 cloud_ok [ocpf_pkg::DEPTH];
    logic [8:0]         width_reg;
    logic [8:0]         height_reg;
    logic [2:0]         radius_reg;

    cloud_item_t  pending_items[$];
    fill_result_t expected_fills[$];
    int           errors;
    int           gap_cnt;
    int           stall_cnt;
    bit           quiet;
    int           cycle_cnt;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic void apply_item(cloud_item_t it);
        int we, he, rad, idx, i, j, k, cnt, uu, vv;
        longint sx, sy, sz;
        fill_result_t res;
        if (it.act == ocpf_pkg::ACT_WRITE) begin
            cloud_x[it.idx]  = it.px;
            cloud_y[it.idx]  = it.py;
            cloud_z[it.idx]  = it.pz;
            cloud_ok[it.idx] = it.ok;
            return;
        end
        we  = (width_reg > ocpf_pkg::MAX_WIDTH) ? ocpf_pkg::MAX_WIDTH : width_reg;
        he  = (height_reg > ocpf_pkg::MAX_HEIGHT) ? ocpf_pkg::MAX_HEIGHT : height_reg;
        rad = (radius_reg > ocpf_pkg::MAX_RADIUS) ? ocpf_pkg::MAX_RADIUS : radius_reg;
        uu  = it.u;
        vv  = it.v;
        res = '{0, 0, 0, ocpf_pkg::ST_RANGE, 0};
        if (uu < we && vv < he) begin
            idx = uu + vv * we;
            if (cloud_ok[idx]) begin
                res = '{cloud_x[idx], cloud_y[idx], cloud_z[idx], ocpf_pkg::ST_HIT, 1};
            end
            else begin
                sx = 0; sy = 0; sz = 0; cnt = 0;
                for (i = uu - rad; i <= uu + rad; i++) begin
                    for (j = vv - rad; j <= vv + rad; j++) begin
                        if (i >= 0 && i < we && j >= 0 && j < he) begin
                            k = i + j * we;
                            if (cloud_ok[k]) begin
                                sx += cloud_x[k];
                                sy += cloud_y[k];
                                sz += cloud_z[k];
                                cnt++;
                            end
                        end
                    end
                end
                if (cnt == 0)
                    res = '{0, 0, 0, ocpf_pkg::ST_EMPTY, 0};
                else
                    res = '{32'(sx / cnt), 32'(sy / cnt), 32'(sz / cnt), ocpf_pkg::ST_AVG,
                            7'(cnt)};
            end
        end
        expected_fills.push_back(res);
    endfunction

    function automatic cloud_item_t mk_write(int idx, logic signed [31:0] x,
                                             logic signed [31:0] y,
                                             logic signed [31:0] z, bit ok);
        cloud_item_t it;
        it = '{ocpf_pkg::ACT_WRITE, 16'(idx), x, y, z, ok, 8'($urandom), 8'($urandom)};
        return it;
    endfunction

    function automatic cloud_item_t mk_query(int u, int v);
        cloud_item_t it;
        it = '{ocpf_pkg::ACT_QUERY, 16'($urandom), $urandom, $urandom, $urandom,
               1'($urandom), 8'(u), 8'(v)};
        return it;
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom_range(0, 20) - 10;
            default: return $urandom;
        endcase
    endfunction

    task automatic write_cfg(logic [1:0] index, logic [8:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        case (index)
            ocpf_pkg::CFG_WIDTH:  width_reg  = value;
            ocpf_pkg::CFG_HEIGHT: height_reg = value;
            default:              radius_reg = value[2:0];
        endcase
    endtask

    task automatic add_random(int n);
        int we, he, su, sv, bu, bv, u, v;
        we = (width_reg > ocpf_pkg::MAX_WIDTH) ? ocpf_pkg::MAX_WIDTH : width_reg;
        he = (height_reg > ocpf_pkg::MAX_HEIGHT) ? ocpf_pkg::MAX_HEIGHT : height_reg;
        su = (we < 12) ? we : 12;
        sv = (he < 12) ? he : 12;
        bu = (we > su) ? $urandom_range(0, we - su) : 0;
        bv = (he > sv) ? $urandom_range(0, he - sv) : 0;
        repeat (n) begin
            if (we == 0 || he == 0 || $urandom_range(0, 9) == 0) begin
                u = $urandom_range(0, 255);
                v = $urandom_range(0, 255);
            end
            else begin
                u = bu + $urandom_range(0, su - 1);
                v = bv + $urandom_range(0, sv - 1);
            end
            if ($urandom_range(0, 1) == 0) begin
                if (we == 0 || he == 0 || $urandom_range(0, 9) == 0)
                    pending_items.push_back(mk_write($urandom_range(0, 65535), rand_coord(),
                                            rand_coord(), rand_coord(), 1'($urandom)));
                else
                    pending_items.push_back(mk_write((u % we) + (v % he) * we, rand_coord(),
                                            rand_coord(), rand_coord(),
                                            $urandom_range(0, 3) != 0));
            end
            else begin
                pending_items.push_back(mk_query(u, v));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid    <= 1'b0;
            action      <= ocpf_pkg::ACT_WRITE;
            point_index <= '0;
            point_x     <= '0;
            point_y     <= '0;
            point_z     <= '0;
            point_ok    <= 1'b0;
            query_u     <= '0;
            query_v     <= '0;
            gap_cnt     <= 0;
        end
        else begin
            if (in_valid && !in_stall)
                apply_item('{action, point_index, point_x, point_y, point_z,
                             point_ok, query_u, query_v});
            if (!in_valid || !in_stall) begin
                if (gap_cnt > 0) begin
                    gap_cnt  <= gap_cnt - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() > 0) begin
                    cloud_item_t it;
                    it = pending_items.pop_front();
                    in_valid    <= 1'b1;
                    action      <= it.act;
                    point_index <= it.idx;
                    point_x     <= it.px;
                    point_y     <= it.py;
                    point_z     <= it.pz;
                    point_ok    <= it.ok;
                    query_u     <= it.u;
                    query_v     <= it.v;
                    if (!quiet && $urandom_range(0, 7) == 0)
                        gap_cnt <= $urandom_range(1, 19);
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_cnt <= 0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (expected_fills.size() == 0) begin
                    $display("%0t: unexpected result x=%0d y=%0d z=%0d status=%0d count=%0d",
                             $time, out_x, out_y, out_z, fill_status, used_count);
                    errors++;
                end
                else begin
                    fill_result_t e;
                    e = expected_fills.pop_front();
                    if (out_x !== e.x || out_y !== e.y || out_z !== e.z ||
                        fill_status !== e.status || used_count !== e.count) begin
                        $display("%0t: mismatch expected x=%0d y=%0d z=%0d status=%0d count=%0d",
                                 $time, e.x, e.y, e.z, e.status, e.count);
                        $display("%0t:          actual   x=%0d y=%0d z=%0d status=%0d count=%0d",
                                 $time, out_x, out_y, out_z, fill_status, used_count);
                        errors++;
                    end
                end
            end
            if (stall_cnt > 0) begin
                out_stall <= 1'b1;
                stall_cnt <= stall_cnt - 1;
            end
            else begin
                out_stall <= 1'b0;
                if (!quiet && $urandom_range(0, 9) == 0)
                    stall_cnt <= $urandom_range(1, 19);
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int p;
        errors     = 0;
        cycle_cnt  = 0;
        quiet      = 1'b0;
        width_reg  = 9'd256;
        height_reg = 9'd256;
        radius_reg = 3'd1;
        foreach (cloud_ok[i]) cloud_ok[i] = 1'b0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = ocpf_pkg::CFG_WIDTH;
        cfg_data  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        pending_items.push_back(mk_query(5, 5));
        pending_items.push_back(mk_write(0, 32'sh7fffffff, 32'sh80000000, -1, 1'b1));
        pending_items.push_back(mk_write(1, 32'sh7fffffff, 32'sh80000000, 1, 1'b1));
        pending_items.push_back(mk_query(0, 0));
        pending_items.push_back(mk_query(0, 1));
        pending_items.push_back(mk_write(257, 32'sh7fffffff, 32'sh7fffffff, -1, 1'b0));
        pending_items.push_back(mk_query(1, 1));
        pending_items.push_back(mk_write(65535, 2, 1, 5, 1'b1));
        pending_items.push_back(mk_query(255, 255));
        pending_items.push_back(mk_write(65534, -3, -4, -5, 1'b1));
        pending_items.push_back(mk_query(255, 254));
        pending_items.push_back(mk_query(254, 254));
        pending_items.push_back(mk_write(0, 0, 0, 0, 1'b0));
        pending_items.push_back(mk_query(0, 0));
        pending_items.push_back(mk_query(3, 0));

        for (p = 0; p < 8; p++) begin
            case (p)
                1: begin
                    write_cfg(ocpf_pkg::CFG_WIDTH, 8);
                    write_cfg(ocpf_pkg::CFG_HEIGHT, 8);
                    write_cfg(ocpf_pkg::CFG_RADIUS, 4);
                end
                2: begin
                    write_cfg(ocpf_pkg::CFG_WIDTH, 1);
                    write_cfg(ocpf_pkg::CFG_HEIGHT, 1);
                    write_cfg(ocpf_pkg::CFG_RADIUS, 0);
                end
                3: begin
                    write_cfg(ocpf_pkg::CFG_WIDTH, 0);
                    write_cfg(ocpf_pkg::CFG_HEIGHT, 5);
                    write_cfg(ocpf_pkg::CFG_RADIUS, 2);
                end
                4: begin
                    write_cfg(ocpf_pkg::CFG_WIDTH, 511);
                    write_cfg(ocpf_pkg::CFG_HEIGHT, 300);
                    write_cfg(ocpf_pkg::CFG_RADIUS, 7);
                end
                5: begin
                    write_cfg(ocpf_pkg::CFG_WIDTH, 17);
                    write_cfg(ocpf_pkg::CFG_HEIGHT, 3);
                    write_cfg(ocpf_pkg::CFG_RADIUS, 3);
                end
                6: begin
                    write_cfg(ocpf_pkg::CFG_WIDTH, 256);
                    write_cfg(ocpf_pkg::CFG_HEIGHT, 256);
                    write_cfg(ocpf_pkg::CFG_RADIUS, 2);
                end
                7: begin
                    write_cfg(ocpf_pkg::CFG_WIDTH, 5);
                    write_cfg(ocpf_pkg::CFG_HEIGHT, 200);
                    write_cfg(ocpf_pkg::CFG_RADIUS, 1);
                end
                default: ;
            endcase
            if (p > 0) begin
                @(posedge clk);
                cfg_we <= 1'b0;
            end
            quiet = (p == 7);
            add_random(140);
            @(posedge clk);
            while (pending_items.size() != 0 || in_valid || expected_fills.size() != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end

        if (expected_fills.size() != 0)
            errors++;
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
